// ===== sv/assert_macros.svh =====
// assertion helpers shared by the statistics core
// every checker samples on clk and is held off while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define SSS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define SSS_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== sv/sss_pkg.sv =====
// shared types, constants and width helpers for the sample set statistics core
// no dependencies
package sss_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int DEV_W         = 15;
  localparam int COUNT_OUT_W   = 13;
  localparam int MAX_COUNT_DEF = 4096;

  // set record queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int QLVL_W  = $clog2(Q_DEPTH + 1);
  localparam int QPTR_W  = $clog2(Q_DEPTH);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } sss_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] minimum;
    logic signed [SAMPLE_W-1:0] maximum;
    logic signed [SAMPLE_W-1:0] mean;
    logic [DEV_W-1:0]           deviation;
    logic [COUNT_OUT_W-1:0]     sample_count;
    logic                       overflow;
  } sss_out_t;

  typedef struct packed {
    logic              empty;
    logic [QLVL_W-1:0] level;
  } sss_qstat_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_DIV_MEAN,
    B_MUL_NS,
    B_MUL_MM,
    B_SUB,
    B_DIV_VAR1,
    B_DIV_VAR2,
    B_SQRT,
    B_DONE
  } sss_back_state_t;

  // width of the sample counter
  function automatic int count_w(input int max_count);
    return $clog2(max_count + 1);
  endfunction

  // signed running sum
  function automatic int sum_w(input int max_count);
    return SAMPLE_W + count_w(max_count);
  endfunction

  // unsigned running sum of squares
  function automatic int sq_w(input int max_count);
    return 2 * SAMPLE_W - 2 + count_w(max_count);
  endfunction

  // one closed set: min, max, sum, sum of squares, count, dropped flag
  function automatic int rec_w(input int max_count);
    return 2 * SAMPLE_W + sum_w(max_count) + sq_w(max_count) + count_w(max_count) + 1;
  endfunction

endpackage

// ===== sv/sample_set_statistics_core.sv =====
// top level of the sample set statistics core
// instantiates sss_front, sss_queue and sss_back; uses sss_pkg
//
// usage
//   input channel: drive item (sample, last) and raise start; the transfer
//   happens at a rising edge with start high and busy low. one sample per
//   cycle is taken while busy stays low.
//   result channel: done is high for exactly one cycle with result holding
//   min, max, mean, deviation, sample_count and overflow of the closed set;
//   the receiver cannot hold it off, the transfer is that single cycle.
// rate and sequencing
//   accumulation runs at one sample per cycle while busy stays low, through
//   a square register and the running sums. each closed set is pushed as one
//   record into a two-entry queue; the back sequencer works it out in turn:
//   mean divide, two serial multiplies, two divides and the square root, one
//   bit or one digit a cycle, over widths PW = 2*SAMPLE_W - 2 +
//   2*clog2(MAX_COUNT+1) and SUMW = SAMPLE_W + clog2(MAX_COUNT+1). with the
//   back idle, a closing transfer passes the input register, the queue and
//   the sequencer states before its result transfer.
//   busy rises once closed sets, counting one still in the input register,
//   would take both queue entries.
// reset
//   rst (synchronous, active high) clears the sums, empties the queue and
//   parks the sequencer; no result is pending afterwards.
module sample_set_statistics_core #(
  parameter int unsigned MAX_COUNT = sss_pkg::MAX_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  sss_pkg::sss_in_t  item,
  output logic              done,
  output sss_pkg::sss_out_t result
);
  import sss_pkg::*;

  localparam int REC_W = rec_w(MAX_COUNT);

  // record path between front and back
  logic             push;
  logic             pop;
  logic [REC_W-1:0] rec_in;
  logic [REC_W-1:0] rec_head;
  sss_qstat_t       qstat;

  // front: input register, capacity check, running min/max/sums
  sss_front #(
    .MAX_COUNT (MAX_COUNT),
    .REC_W     (REC_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .qstat    (qstat),
    .push     (push),
    .rec_data (rec_in)
  );

  // queue of closed sets, lets a new set accumulate while the last one is worked out
  sss_queue #(
    .REC_W (REC_W)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (rec_in),
    .pop   (pop),
    .rdata (rec_head),
    .stat  (qstat)
  );

  // back: mean, variance and deviation, then the one-cycle result strobe
  sss_back #(
    .MAX_COUNT (MAX_COUNT),
    .REC_W     (REC_W)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (rec_head),
    .qstat  (qstat),
    .pop    (pop),
    .done   (done),
    .result (result)
  );

endmodule

// ===== sv/sss_front.sv =====
// front part: takes samples, sorts them into kept, dropped and set-closing,
// keeps the running sums and pushes one record per set; uses sss_pkg
`include "assert_macros.svh"

module sss_front #(
  parameter int unsigned MAX_COUNT = sss_pkg::MAX_COUNT_DEF,
  parameter int          REC_W     = sss_pkg::rec_w(sss_pkg::MAX_COUNT_DEF)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  sss_pkg::sss_in_t   item,
  input  sss_pkg::sss_qstat_t qstat,
  output logic               push,
  output logic [REC_W-1:0]   rec_data
);
  import sss_pkg::*;

  localparam int CW   = count_w(MAX_COUNT);
  localparam int SUMW = sum_w(MAX_COUNT);
  localparam int SQW  = sq_w(MAX_COUNT);
  localparam int SQ1W = 2 * SAMPLE_W - 1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] minimum;
    logic signed [SAMPLE_W-1:0] maximum;
    logic signed [SUMW-1:0]     sum;
    logic [SQW-1:0]             sumsq;
    logic [CW-1:0]              n;
    logic                       dropped;
  } rec_t;

  logic                       accept;
  logic signed [2*SAMPLE_W-1:0] sq_full;

  // input register stage
  logic                       s1_valid;
  logic                       s1_last;
  logic signed [SAMPLE_W-1:0] s1_x;
  logic [SQ1W-1:0]            s1_sq;

  logic signed [SAMPLE_W-1:0] running_min, running_min_next;
  logic signed [SAMPLE_W-1:0] running_max, running_max_next;
  logic signed [SUMW-1:0]     running_sum, running_sum_next;
  logic [SQW-1:0]             running_sum_squares, running_sum_squares_next;
  logic [CW-1:0]              count_so_far, count_so_far_next;
  logic                       dropped_flag, dropped_flag_next;
  logic                       full;
  rec_t                       rec;

  assign accept  = start && !busy;
  assign sq_full = item.sample * item.sample;

  // a set-closing item still in the input stage will need a queue slot
  assign busy = ({1'b0, qstat.level} + {{QLVL_W{1'b0}}, s1_valid && s1_last})
                >= (QLVL_W + 1)'(Q_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_last <= item.last;
      s1_x    <= item.sample;
      s1_sq   <= sq_full[SQ1W-1:0];
    end
  end

  assign full = (count_so_far == CW'(MAX_COUNT));

  always_comb begin
    running_min_next         = running_min;
    running_max_next         = running_max;
    running_sum_next         = running_sum;
    running_sum_squares_next = running_sum_squares;
    count_so_far_next        = count_so_far;
    dropped_flag_next        = dropped_flag;
    if (s1_valid) begin
      if (full) begin
        dropped_flag_next = 1'b1;
      end else begin
        if (count_so_far == '0) begin
          running_min_next = s1_x;
          running_max_next = s1_x;
        end else begin
          if (s1_x < running_min) running_min_next = s1_x;
          if (s1_x > running_max) running_max_next = s1_x;
        end
        running_sum_next         = running_sum + SUMW'(s1_x);
        running_sum_squares_next = running_sum_squares + SQW'(s1_sq);
        count_so_far_next        = count_so_far + CW'(1);
      end
    end
  end

  always_comb begin
    rec.minimum = running_min_next;
    rec.maximum = running_max_next;
    rec.sum     = running_sum_next;
    rec.sumsq   = running_sum_squares_next;
    rec.n       = count_so_far_next;
    rec.dropped = dropped_flag_next;
  end

  assign push     = s1_valid && s1_last;
  assign rec_data = rec;

  always_ff @(posedge clk) begin
    if (rst || push) begin
      running_min         <= '0;
      running_max         <= '0;
      running_sum         <= '0;
      running_sum_squares <= '0;
      count_so_far        <= '0;
      dropped_flag        <= 1'b0;
    end else begin
      running_min         <= running_min_next;
      running_max         <= running_max_next;
      running_sum         <= running_sum_next;
      running_sum_squares <= running_sum_squares_next;
      count_so_far        <= count_so_far_next;
      dropped_flag        <= dropped_flag_next;
    end
  end

  `SSS_ASSERT_ALWAYS(a_count_in_range, count_so_far <= CW'(MAX_COUNT), "count past capacity")

endmodule

// ===== sv/sss_queue.sv =====
// short record queue between the front and back parts
// uses sss_pkg for depth and status type
`include "assert_macros.svh"

module sss_queue #(
  parameter int REC_W = sss_pkg::rec_w(sss_pkg::MAX_COUNT_DEF)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [REC_W-1:0]    wdata,
  input  logic                pop,
  output logic [REC_W-1:0]    rdata,
  output sss_pkg::sss_qstat_t stat
);
  import sss_pkg::*;

  logic [REC_W-1:0]  entries [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QLVL_W-1:0] level;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({push, pop})
        2'b10:   level <= level + QLVL_W'(1);
        2'b01:   level <= level - QLVL_W'(1);
        default: level <= level;
      endcase
    end
  end

  assign rdata      = entries[rd_ptr];
  assign stat.level = level;
  assign stat.empty = (level == '0);

  `SSS_ASSERT_IMPLIES(a_no_overfill, push, level != QLVL_W'(Q_DEPTH), "push into full queue")
  `SSS_ASSERT_IMPLIES(a_no_underrun, pop, level != '0, "pop from empty queue")

endmodule

// ===== sv/sss_back.sv =====
// back part: per-set sequencer with a shared restoring divider, shift-add
// multiplier and digit-by-digit square root; uses sss_pkg
`include "assert_macros.svh"

module sss_back #(
  parameter int unsigned MAX_COUNT = sss_pkg::MAX_COUNT_DEF,
  parameter int          REC_W     = sss_pkg::rec_w(sss_pkg::MAX_COUNT_DEF)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [REC_W-1:0]    head,
  input  sss_pkg::sss_qstat_t qstat,
  output logic                pop,
  output logic                done,
  output sss_pkg::sss_out_t   result
);
  import sss_pkg::*;

  localparam int CW    = count_w(MAX_COUNT);
  localparam int SUMW  = sum_w(MAX_COUNT);
  localparam int SQW   = sq_w(MAX_COUNT);
  localparam int PW    = 2 * SAMPLE_W - 2 + 2 * CW;  // n*sumsq, always even
  localparam int HW    = PW / 2;                     // root width
  localparam int RW    = HW + 1;                     // root remainder width
  localparam int CNT_W = $clog2(PW);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] minimum;
    logic signed [SAMPLE_W-1:0] maximum;
    logic signed [SUMW-1:0]     sum;
    logic [SQW-1:0]             sumsq;
    logic [CW-1:0]              n;
    logic                       dropped;
  } rec_t;

  sss_back_state_t state, state_next;
  logic [CNT_W-1:0] cnt;
  logic             last_div, last_mul, last_sqrt;

  rec_t             head_rec;
  rec_t             rec;
  logic [SUMW-1:0]  head_mag, mag;
  logic [SUMW-1:0]  mean_mag;
  logic signed [SUMW-1:0] mean_full;

  // divider
  logic [PW-1:0]    dv, dv_step;
  logic [CW-1:0]    rem, rem_step;
  logic [CW:0]      rem_sh;
  logic             div_ge;

  // multiplier
  logic [PW-1:0]    mul_acc, mul_a, acc_step, prod_p;
  logic [SUMW-1:0]  mul_b;

  // square root
  logic [PW-1:0]    sr;
  logic [HW-1:0]    root;
  logic [RW-1:0]    srem;
  logic [RW+1:0]    srem_sh, trial;
  logic             sq_ge;

  assign head_rec = head;
  assign head_mag = head_rec.sum[SUMW-1] ? SUMW'(-head_rec.sum) : SUMW'(head_rec.sum);
  assign mag      = rec.sum[SUMW-1] ? SUMW'(-rec.sum) : SUMW'(rec.sum);

  assign last_div  = (cnt == CNT_W'(PW - 1));
  assign last_mul  = (cnt == CNT_W'(SUMW - 1));
  assign last_sqrt = (cnt == CNT_W'(HW - 1));

  // one restoring divide step by n
  assign rem_sh   = {rem, dv[PW-1]};
  assign div_ge   = rem_sh >= {1'b0, rec.n};
  assign rem_step = div_ge ? CW'(rem_sh - {1'b0, rec.n}) : rem_sh[CW-1:0];
  assign dv_step  = {dv[PW-2:0], div_ge};

  // one shift-add multiply step
  assign acc_step = mul_b[0] ? mul_acc + mul_a : mul_acc;

  // one square root digit
  assign srem_sh = {srem, sr[PW-1:PW-2]};
  assign trial   = (RW + 2)'({root, 2'b01});
  assign sq_ge   = srem_sh >= trial;

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:     if (!qstat.empty) state_next = B_DIV_MEAN;
      B_DIV_MEAN: if (last_div)     state_next = B_MUL_NS;
      B_MUL_NS:   if (last_mul)     state_next = B_MUL_MM;
      B_MUL_MM:   if (last_mul)     state_next = B_SUB;
      B_SUB:                        state_next = B_DIV_VAR1;
      B_DIV_VAR1: if (last_div)     state_next = B_DIV_VAR2;
      B_DIV_VAR2: if (last_div)     state_next = B_SQRT;
      B_SQRT:     if (last_sqrt)    state_next = B_DONE;
      B_DONE:                       state_next = B_IDLE;
      default:                      state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop  = 1'b0;
    done = 1'b0;
    unique case (state)
      B_IDLE:  pop  = !qstat.empty;
      B_DONE:  done = 1'b1;
      default: begin
        pop  = 1'b0;
        done = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state_next != state) cnt <= '0;
      else                     cnt <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (!qstat.empty) begin
          rec <= head_rec;
          dv  <= PW'(head_mag);
          rem <= '0;
        end
      end
      B_DIV_MEAN: begin
        dv  <= dv_step;
        rem <= rem_step;
        if (last_div) begin
          mean_mag <= dv_step[SUMW-1:0];
          mul_acc  <= '0;
          mul_a    <= PW'(rec.sumsq);
          mul_b    <= SUMW'(rec.n);
        end
      end
      B_MUL_NS, B_MUL_MM: begin
        if (state == B_MUL_NS && last_mul) begin
          prod_p  <= acc_step;
          mul_acc <= '0;
          mul_a   <= PW'(mag);
          mul_b   <= mag;
        end else begin
          mul_acc <= acc_step;
          mul_a   <= {mul_a[PW-2:0], 1'b0};
          mul_b   <= {1'b0, mul_b[SUMW-1:1]};
        end
      end
      B_SUB: begin
        dv  <= prod_p - mul_acc;
        rem <= '0;
      end
      B_DIV_VAR1, B_DIV_VAR2: begin
        dv <= dv_step;
        if (last_div) begin
          rem <= '0;
          if (state == B_DIV_VAR2) begin
            sr   <= dv_step;
            srem <= '0;
            root <= '0;
          end
        end else begin
          rem <= rem_step;
        end
      end
      B_SQRT: begin
        sr   <= {sr[PW-3:0], 2'b00};
        srem <= sq_ge ? RW'(srem_sh - trial) : RW'(srem_sh);
        root <= {root[HW-2:0], sq_ge};
      end
      default: begin
      end
    endcase
  end

  assign mean_full = rec.sum[SUMW-1] ? -$signed(mean_mag) : $signed(mean_mag);

  always_comb begin
    result.minimum      = rec.minimum;
    result.maximum      = rec.maximum;
    result.mean         = mean_full[SAMPLE_W-1:0];
    result.deviation    = root[DEV_W-1:0];
    result.sample_count = COUNT_OUT_W'(rec.n);
    result.overflow     = rec.dropped;
  end

  `SSS_ASSERT_IMPLIES(a_done_has_samples, done, rec.n != '0, "result for an empty set")

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for sample_set_statistics_core: samples in, set statistics out
// predicts every closed set with exact integer sums; depends on sss_pkg and the core RTL
module tb;

  import sss_pkg::*;

  // block built at its default capacity; the sets sent here stay well below it
  localparam int unsigned SET_CAPACITY = MAX_COUNT_DEF;
  // quiet tail after the last owed result, to catch stray result transfers
  localparam int TAIL_CYCLES = 400;
  localparam longint CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_ITEMS = 1030;
  localparam int REPORT_LIMIT = 10;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  sss_in_t  item;
  logic     done;
  sss_out_t result;

  sample_set_statistics_core #(
    .MAX_COUNT(SET_CAPACITY)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .done(done),
    .result(result)
  );

  // free-running clock, period 2
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // predicted state of the set being gathered
  // -------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] set_min;
  logic signed [SAMPLE_W-1:0] set_max;
  longint                     set_sum;
  longint unsigned            set_sumsq;
  longint unsigned            set_count;
  logic                       set_dropped;

  // statistics of closed sets still owed by the block, oldest first
  sss_out_t pending_set_stats[$];

  int     fail_count;
  int     items_sent;
  int     sets_checked;
  int     overflow_sets;
  int     idle_pct;
  longint cycle_count;
  sss_out_t want;

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("mismatch: %s", msg);
  endtask

  // fold one transferred sample into the running set; on last, work out the
  // set statistics exactly and queue them, then clear for the next set
  task automatic fold_sample_into_set(input logic signed [SAMPLE_W-1:0] s, input logic l);
    sss_out_t        stats;
    longint unsigned mag;
    longint unsigned spread;
    longint unsigned root;
    longint unsigned trial;
    if (set_count >= SET_CAPACITY) begin
      // set is full: the sample is dropped but last still closes the set
      set_dropped = 1'b1;
    end else begin
      if (set_count == 0) begin
        set_min = s;
        set_max = s;
      end else begin
        if (s < set_min) set_min = s;
        if (s > set_max) set_max = s;
      end
      set_sum   += longint'(s);
      set_sumsq += longint'(s) * longint'(s);
      set_count++;
    end
    if (!l) return;

    // population variance floor((n*sumsq - sum^2) / n^2); fits 64 bits at 4096
    mag    = (set_sum < 0) ? -set_sum : set_sum;
    spread = (set_count * set_sumsq - mag * mag) / (set_count * set_count);
    root   = 0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= spread) root = trial;
    end

    stats.minimum      = set_min;
    stats.maximum      = set_max;
    stats.mean         = SAMPLE_W'(set_sum / longint'(set_count));  // truncates toward zero
    stats.deviation    = DEV_W'(root);
    stats.sample_count = COUNT_OUT_W'(set_count);
    stats.overflow     = set_dropped;
    pending_set_stats.push_back(stats);
    if (set_dropped) overflow_sets++;

    set_min     = '0;
    set_max     = '0;
    set_sum     = 0;
    set_sumsq   = 0;
    set_count   = 0;
    set_dropped = 1'b0;
  endtask

  // -------------------------------------------------------------------------
  // sender: one sample per call; each cycle before it is idle at random with
  // the chance idle_pct; start is left high after the transfer so
  // back-to-back samples need no gap
  // -------------------------------------------------------------------------
  task automatic drive_sample(input logic signed [SAMPLE_W-1:0] s, input logic l);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      item  <= 17'($urandom);  // junk on the bus while idle
    end
    @(negedge clk);
    start <= 1'b1;
    item  <= '{sample: s, last: l};
    @(posedge clk);
    while (busy) @(posedge clk);
    fold_sample_into_set(s, l);
    items_sent++;
  endtask

  // sender holds off until the block has delivered every owed result
  task automatic wait_for_drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_set_stats.size() != 0) @(posedge clk);
  endtask

  // -------------------------------------------------------------------------
  // result checker: every done cycle is one transfer, matched to the oldest
  // predicted set
  // -------------------------------------------------------------------------
  task automatic compare_field(input string name, input longint exp_v, input longint got_v);
    if (exp_v != got_v)
      note_failure($sformatf("set %0d %s expected %0d got %0d",
                             sets_checked, name, exp_v, got_v));
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (!rst && done) begin
      if (pending_set_stats.size() == 0) begin
        note_failure("result transfer with no closed set waiting");
      end else begin
        want = pending_set_stats.pop_front();
        compare_field("minimum", longint'(want.minimum), longint'(result.minimum));
        compare_field("maximum", longint'(want.maximum), longint'(result.maximum));
        compare_field("mean", longint'(want.mean), longint'(result.mean));
        compare_field("deviation", longint'(want.deviation), longint'(result.deviation));
        compare_field("sample_count", longint'(want.sample_count),
                      longint'(result.sample_count));
        compare_field("overflow", longint'(want.overflow), longint'(result.overflow));
        sets_checked++;
      end
    end
  end

  // watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d sets still owed",
             cycle_count, pending_set_stats.size());
    $display("Regression FAIL");
    $finish;
  end

  // -------------------------------------------------------------------------
  // test tasks
  // -------------------------------------------------------------------------

  // one-sample sets at the ends of the range and at zero
  task automatic test_single_sample_sets();
    drive_sample(16'sh7fff, 1'b1);
    drive_sample(-16'sh8000, 1'b1);
    drive_sample(16'sh0000, 1'b1);
  endtask

  // mean truncation toward zero on both signs, plus the widest spread
  task automatic test_mean_rounding();
    drive_sample(-16'sd3, 1'b0);
    drive_sample(-16'sd4, 1'b1);
    drive_sample(16'sd3, 1'b0);
    drive_sample(16'sd4, 1'b1);
    drive_sample(-16'sh8000, 1'b0);
    drive_sample(16'sh7fff, 1'b1);
  endtask

  // min and max must be seeded by the first sample, not by the cleared zero
  task automatic test_min_max_seeding();
    drive_sample(16'sd100, 1'b0);
    drive_sample(16'sd5, 1'b0);
    drive_sample(16'sd300, 1'b1);
    drive_sample(-16'sd100, 1'b0);
    drive_sample(-16'sd5, 1'b0);
    drive_sample(-16'sd300, 1'b1);
  endtask

  // alternating bit patterns, then a flat set whose deviation is zero
  task automatic test_patterns_and_flat_set();
    drive_sample(16'sh5555, 1'b0);
    drive_sample(-16'sh5556, 1'b1);  // 0xaaaa
    drive_sample(16'sd7, 1'b0);
    drive_sample(16'sd7, 1'b0);
    drive_sample(16'sd7, 1'b1);
  endtask

  // random sets, mostly short; value style chosen per set; a quiet stretch
  // with no idling in the middle and an occasional full drain
  task automatic test_random_sets(input int target);
    int first;
    int len;
    int style;
    int centre;
    logic signed [SAMPLE_W-1:0] s;
    first = items_sent;
    while (items_sent - first < target) begin
      idle_pct = (items_sent - first > target / 3 && items_sent - first < target / 2) ? 0 : 18;
      len    = ($urandom_range(9) == 0) ? $urandom_range(9, 60) : $urandom_range(1, 8);
      style  = $urandom_range(3);
      centre = $urandom_range(65535) - 32768;
      for (int k = 0; k < len; k++) begin
        case (style)
          0: begin
            s = 16'($urandom);
          end
          1: begin
            case ($urandom_range(4))
              0: s = -16'sh8000;
              1: s = 16'sh7fff;
              2: s = 16'sh0000;
              3: s = -16'sd1;
              default: s = 16'sd1;
            endcase
          end
          2: begin
            // tight cluster: small deviation, mean near the centre
            s = 16'(centre + $urandom_range(64) - 32);
          end
          default: begin
            // one sign only
            s = centre < 0 ? -16'($urandom_range(32768)) : 16'($urandom_range(32767));
          end
        endcase
        drive_sample(s, k == len - 1);
      end
      if ($urandom_range(24) == 0) wait_for_drain();
    end
    idle_pct = 18;
  endtask

  // -------------------------------------------------------------------------
  // main sequence
  // -------------------------------------------------------------------------
  initial begin
    rst           = 1'b1;
    start         = 1'b0;
    item          = '0;
    set_min       = '0;
    set_max       = '0;
    set_sum       = 0;
    set_sumsq     = 0;
    set_count     = 0;
    set_dropped   = 1'b0;
    fail_count    = 0;
    items_sent    = 0;
    sets_checked  = 0;
    overflow_sets = 0;
    idle_pct      = 18;
    cycle_count   = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_single_sample_sets();
    test_mean_rounding();
    wait_for_drain();
    test_min_max_seeding();
    test_patterns_and_flat_set();
    wait_for_drain();
    test_random_sets(RANDOM_ITEMS);

    // stop sending, collect the owed results, then watch for strays
    @(negedge clk);
    start <= 1'b0;
    while (pending_set_stats.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_set_stats.size() != 0)
      note_failure($sformatf("%0d sets never reported", pending_set_stats.size()));

    $display("%0d samples sent in %0d checked sets, %0d of them overrun past capacity",
             items_sent, sets_checked, overflow_sets);
    $display("%0d failures in %0d cycles", fail_count, cycle_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/sss_pkg.sv
sv/sss_front.sv
sv/sss_queue.sv
sv/sss_back.sv
sv/sample_set_statistics_core.sv
tb/tb.sv
